// ----- sv/tpc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpc_pkg
// Shared types, constants and helpers for the target pressure classifier.
// ----------------------------------------------------------------------------
package tpc_pkg;

    localparam int NUM_TARGETS_DEF = 16;
    localparam int MAX_RECS_DEF    = 16;
    localparam int IDX_W           = 4;
    localparam int QUEUE_DEPTH     = 2;
    localparam int REG_IDX_W       = 3;
    localparam int CFG_W           = 64;

    typedef enum logic [1:0] {
        CMD_UPDATE  = 2'd0,
        CMD_CLEARED = 2'd1,
        CMD_ROUND   = 2'd2,
        CMD_RECOMMEND = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        LVL_NORMAL      = 2'd0,
        LVL_WATCH       = 2'd1,
        LVL_CONSTRAINED = 2'd2
    } level_t;

    localparam logic [REG_IDX_W-1:0] REG_PB_TH     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_Q_TH      = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_SS_TH     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_DROP_TH   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_RECOVERY  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_CONS_SMP  = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_WATCH_SMP = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_COOLDOWN  = 3'd7;

    localparam logic [15:0] RUN_MAX    = 16'hFFFF;
    localparam logic [2:0]  NO_SIGNAL  = 3'd4;

    // decoded work item passed from front to back
    typedef struct packed {
        cmd_t        cmd;
        logic        in_range;
        logic [IDX_W-1:0] idx;
        logic [1:0]  metric;
        logic [31:0] pv;
        logic [31:0] pb;
        logic [47:0] now;
    } work_t;

    typedef struct packed {
        logic [3:0][63:0] th;
        logic [15:0] recovery;
        logic [15:0] cons_smp;
        logic [15:0] watch_smp;
        logic [31:0] cooldown;
    } cfg_t;

    function automatic logic [15:0] run_inc(input logic [15:0] r);
        run_inc = (r == RUN_MAX) ? RUN_MAX : r + 16'd1;
    endfunction

    function automatic logic [31:0] smooth(input logic [31:0] o, input logic [31:0] v);
        logic [33:0] w;
        w = {2'b00, o} + {1'b0, o, 1'b0} + {2'b00, v};
        smooth = w[33:2];
    endfunction

endpackage

// ----- sv/tpc_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpc_in_if
// Input channel: command beat with valid/ready.
// ----------------------------------------------------------------------------
interface tpc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [3:0]  target_index;
    logic [1:0]  metric;
    logic [31:0] pressure_sample;
    logic [31:0] pending_sample;
    logic [47:0] now_ms;
    logic [1:0]  rec_type;

    modport source (output valid, cmd, target_index, metric, pressure_sample,
                    pending_sample, now_ms, rec_type, input ready);
    modport sink (input valid, cmd, target_index, metric, pressure_sample,
                  pending_sample, now_ms, rec_type, output ready);
endinterface

// ----- sv/tpc_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpc_out_if
// Result channel: entry status beat with valid/ready.
// ----------------------------------------------------------------------------
interface tpc_out_if;
    logic        valid;
    logic        ready;
    logic        entry_valid;
    logic [1:0]  level;
    logic [31:0] pressure_avg;
    logic [31:0] pending_avg;
    logic [15:0] watch_run;
    logic [15:0] constrained_run;
    logic [15:0] normal_run;
    logic [47:0] started_ms;
    logic [47:0] normal_since_out;
    logic        recommended;
    logic [2:0]  signal;

    modport source (output valid, entry_valid, level, pressure_avg, pending_avg,
                    watch_run, constrained_run, normal_run, started_ms,
                    normal_since_out, recommended, signal, input ready);
    modport sink (input valid, entry_valid, level, pressure_avg, pending_avg,
                  watch_run, constrained_run, normal_run, started_ms,
                  normal_since_out, recommended, signal, output ready);
endinterface

// ----- sv/tpc_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpc_front
// Accepts command beats, decodes them and pushes them into a short queue.
// ----------------------------------------------------------------------------
module tpc_front #(
    parameter int NUM_TARGETS = tpc_pkg::NUM_TARGETS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    tpc_in_if.sink         in_ch,
    output tpc_pkg::work_t q_data,
    output logic           q_valid,
    input  logic           q_ready
);
    localparam int CNT_W = $clog2(tpc_pkg::QUEUE_DEPTH + 1);

    tpc_pkg::work_t            mem_reg [tpc_pkg::QUEUE_DEPTH];
    logic                      wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]          cnt_reg;
    tpc_pkg::work_t            dec;
    logic                      push, pop;

    // decode the incoming beat
    always_comb
    begin
        dec.cmd      = tpc_pkg::cmd_t'(in_ch.cmd);
        dec.in_range = ({28'd0, in_ch.target_index} < 32'(NUM_TARGETS));
        dec.idx      = in_ch.target_index;
        dec.metric   = in_ch.metric;
        dec.pv       = in_ch.pressure_sample;
        dec.pb       = in_ch.pending_sample;
        dec.now      = in_ch.now_ms;
    end

    assign in_ch.ready = (cnt_reg != CNT_W'(tpc_pkg::QUEUE_DEPTH));
    assign push        = in_ch.valid && in_ch.ready;
    assign q_valid     = (cnt_reg != '0);
    assign pop         = q_valid && q_ready;
    assign q_data      = mem_reg[rd_ptr_reg];

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= dec;
        end
    end

    // queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)      cnt_reg <= cnt_reg + CNT_W'(1);
            else if (pop && !push) cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(tpc_pkg::QUEUE_DEPTH)) else $error("queue overflow");
    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> cnt_reg == $past(cnt_reg) + CNT_W'(1))
        else $error("queue count");
    a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        pop && !push |=> cnt_reg == $past(cnt_reg) - CNT_W'(1))
        else $error("queue count");
`endif
endmodule

// ----- sv/tpc_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpc_back
// Per-entry read-modify-write: smoothing, level, runs, times, recommends.
// ----------------------------------------------------------------------------
module tpc_back #(
    parameter int NUM_TARGETS = tpc_pkg::NUM_TARGETS_DEF,
    parameter int MAX_RECS    = tpc_pkg::MAX_RECS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  tpc_pkg::cfg_t  cfg,
    input  tpc_pkg::work_t q_data,
    input  logic           q_valid,
    output logic           q_ready,
    tpc_out_if.source      out_ch
);
    localparam int RC_W = $clog2(MAX_RECS + 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } st_t;

    // entry tables (one per target, indexed by the working item)
    logic [NUM_TARGETS-1:0] used_reg;
    logic [1:0]  metric_tab  [NUM_TARGETS];
    logic [1:0]  level_tab   [NUM_TARGETS];
    logic [31:0] ps_tab      [NUM_TARGETS];
    logic [31:0] pd_tab      [NUM_TARGETS];
    logic [15:0] wrun_tab    [NUM_TARGETS];
    logic [15:0] crun_tab    [NUM_TARGETS];
    logic [15:0] nrun_tab    [NUM_TARGETS];
    logic [47:0] start_tab   [NUM_TARGETS];
    logic [47:0] nsince_tab  [NUM_TARGETS];
    logic [47:0] last_tab    [NUM_TARGETS];

    st_t              st_reg;
    tpc_pkg::work_t   w_reg;
    logic [RC_W-1:0]  round_reg;
    logic             ov_reg;

    logic [3:0]  i;
    logic        ok, used;
    logic [1:0]  lvl_o, lvl_n, met_n;
    logic [31:0] ps_n, pd_n, wth, cth, pv_in;
    logic [15:0] wr_n, cr_n, nr_n;
    logic [47:0] st_n, ns_n, ls_n, last_o;
    logic        wr_en, used_n, rec, enough, cool_ok;
    logic [63:0] th;
    logic [47:0] gap;
    logic        out_free;

    assign i   = w_reg.idx;
    assign ok  = w_reg.in_range;
    assign used = ok && used_reg[i];
    assign out_free = !ov_reg || out_ch.ready;
    assign q_ready  = (st_reg == ST_IDLE);

    // next entry state for the held item
    always_comb
    begin
        th     = cfg.th[w_reg.metric];
        wth    = th[31:0];
        cth    = th[63:32];
        pv_in  = (w_reg.cmd == tpc_pkg::CMD_CLEARED) ? 32'd0 : w_reg.pv;
        lvl_o  = level_tab[i];
        last_o = last_tab[i];
        met_n  = metric_tab[i];
        lvl_n  = lvl_o;
        ps_n   = ps_tab[i];
        pd_n   = pd_tab[i];
        wr_n   = wrun_tab[i];
        cr_n   = crun_tab[i];
        nr_n   = nrun_tab[i];
        st_n   = start_tab[i];
        ns_n   = nsince_tab[i];
        ls_n   = last_o;
        used_n = used;
        wr_en  = 1'b0;
        rec    = 1'b0;
        enough = 1'b0;
        cool_ok = 1'b0;
        gap    = w_reg.now - last_o;
        case (w_reg.cmd)
            tpc_pkg::CMD_UPDATE, tpc_pkg::CMD_CLEARED:
            begin
                if (ok && (used || w_reg.cmd == tpc_pkg::CMD_UPDATE))
                begin
                    wr_en  = 1'b1;
                    used_n = 1'b1;
                    if (!used)
                    begin
                        lvl_o = tpc_pkg::LVL_NORMAL;
                        ps_n = pv_in; pd_n = w_reg.pb;
                        wr_n = '0; cr_n = '0; nr_n = '0;
                        st_n = '0; ns_n = '0; ls_n = '0;
                    end
                    else
                    begin
                        ps_n = tpc_pkg::smooth(ps_tab[i], pv_in);
                        pd_n = tpc_pkg::smooth(pd_tab[i], w_reg.pb);
                    end
                    met_n = w_reg.metric;
                    if (cth != 32'd0 && ps_n >= cth)
                    begin
                        lvl_n = tpc_pkg::LVL_CONSTRAINED;
                        cr_n = tpc_pkg::run_inc(cr_n);
                        wr_n = tpc_pkg::run_inc(wr_n);
                        nr_n = '0; ns_n = '0;
                        if (st_n == '0) st_n = w_reg.now;
                    end
                    else if (wth != 32'd0 && ps_n >= wth)
                    begin
                        lvl_n = tpc_pkg::LVL_WATCH;
                        cr_n = '0;
                        wr_n = tpc_pkg::run_inc(wr_n);
                        nr_n = '0; ns_n = '0;
                        if (st_n == '0) st_n = w_reg.now;
                    end
                    else
                    begin
                        lvl_n = tpc_pkg::LVL_NORMAL;
                        cr_n = '0; wr_n = '0;
                        nr_n = tpc_pkg::run_inc(nr_n);
                        if (lvl_o != tpc_pkg::LVL_NORMAL) ns_n = w_reg.now;
                        if (nr_n >= cfg.recovery) st_n = '0;
                    end
                end
            end
            tpc_pkg::CMD_RECOMMEND:
            begin
                enough = (lvl_o == tpc_pkg::LVL_CONSTRAINED && crun_tab[i] >= cfg.cons_smp) ||
                         (lvl_o == tpc_pkg::LVL_WATCH && wrun_tab[i] >= cfg.watch_smp);
                cool_ok = (last_o == '0) ||
                          (w_reg.now >= last_o && gap >= {16'd0, cfg.cooldown});
                if (used && round_reg < RC_W'(MAX_RECS) && enough && cool_ok)
                begin
                    rec = 1'b1;
                    wr_en = 1'b1;
                    ls_n = w_reg.now;
                end
            end
            default:
            begin
            end
        endcase
    end

    // table writes
    always_ff @(posedge clk)
    begin
        if (st_reg == ST_EXEC && out_free && wr_en)
        begin
            metric_tab[i] <= met_n;
            level_tab[i]  <= lvl_n;
            ps_tab[i]     <= ps_n;
            pd_tab[i]     <= pd_n;
            wrun_tab[i]   <= wr_n;
            crun_tab[i]   <= cr_n;
            nrun_tab[i]   <= nr_n;
            start_tab[i]  <= st_n;
            nsince_tab[i] <= ns_n;
            last_tab[i]   <= ls_n;
        end
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (st_reg == ST_EXEC && out_free)
        begin
            out_ch.entry_valid      <= used_n;
            out_ch.level            <= used_n ? lvl_n : 2'd0;
            out_ch.pressure_avg     <= used_n ? ps_n : 32'd0;
            out_ch.pending_avg      <= used_n ? pd_n : 32'd0;
            out_ch.watch_run        <= used_n ? wr_n : 16'd0;
            out_ch.constrained_run  <= used_n ? cr_n : 16'd0;
            out_ch.normal_run       <= used_n ? nr_n : 16'd0;
            out_ch.started_ms       <= used_n ? st_n : 48'd0;
            out_ch.normal_since_out <= used_n ? ns_n : 48'd0;
            out_ch.recommended      <= rec;
            out_ch.signal           <= used_n ? {1'b0, met_n} : tpc_pkg::NO_SIGNAL;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_valid && q_ready)
        begin
            w_reg <= q_data;
        end
    end

    // control: sequencer, valid bits, round counter, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= ST_IDLE;
            used_reg  <= '0;
            round_reg <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            case (st_reg)
                ST_IDLE:
                begin
                    if (q_valid) st_reg <= ST_EXEC;
                end
                ST_EXEC:
                begin
                    if (out_free)
                    begin
                        st_reg <= ST_IDLE;
                        if (wr_en) used_reg[i] <= 1'b1;
                        if (w_reg.cmd == tpc_pkg::CMD_ROUND) round_reg <= '0;
                        else if (rec) round_reg <= round_reg + RC_W'(1);
                    end
                end
                default: st_reg <= ST_IDLE;
            endcase
            // result valid: set on load, cleared once taken
            if (st_reg == ST_EXEC && out_free) ov_reg <= 1'b1;
            else if (out_ch.ready) ov_reg <= 1'b0;
        end
    end

    assign out_ch.valid = ov_reg;

`ifndef SYNTHESIS
    a_round_cap: assert property (@(posedge clk) disable iff (!rst_n)
        round_reg <= RC_W'(MAX_RECS)) else $error("round count past limit");
    a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(st_reg)) else $error("sequencer code");
    a_rec_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.recommended |-> out_ch.entry_valid)
        else $error("recommend without entry");
    a_rec_level: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.recommended |-> out_ch.level != tpc_pkg::LVL_NORMAL)
        else $error("recommend at normal level");
`endif
endmodule

// ----- sv/target_pressure_classifier.sv -----
`timescale 1ns / 1ps
// a beat passes queue, work and result registers; the result loads if output is free
// the back end's read-modify-write sequencer takes one beat at a time, idle then exec
// a 2-entry queue decouples acceptance from the back end
// reset: entries invalid, round count 0, registers at their reset values
// ----------------------------------------------------------------------------
// target_pressure_classifier
// Tracked target table with smoothed pressure classification and recommends.
// ----------------------------------------------------------------------------
module target_pressure_classifier #(
    parameter int NUM_TARGETS = tpc_pkg::NUM_TARGETS_DEF,
    parameter int MAX_RECS    = tpc_pkg::MAX_RECS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    tpc_in_if.sink                        in_ch,
    tpc_out_if.source                     out_ch,
    input  logic                          cfg_we,
    input  logic [tpc_pkg::REG_IDX_W-1:0] cfg_index,
    input  logic [tpc_pkg::CFG_W-1:0]     cfg_data
);
    tpc_pkg::cfg_t  cfg_reg;
    tpc_pkg::work_t q_data;
    logic           q_valid, q_ready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.th[0]     <= '0;
            cfg_reg.th[1]     <= '0;
            cfg_reg.th[2]     <= '0;
            cfg_reg.th[3]     <= '0;
            cfg_reg.recovery  <= 16'd3;
            cfg_reg.cons_smp  <= 16'd1;
            cfg_reg.watch_smp <= 16'd1;
            cfg_reg.cooldown  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tpc_pkg::REG_PB_TH:     cfg_reg.th[0] <= cfg_data;
                tpc_pkg::REG_Q_TH:      cfg_reg.th[1] <= cfg_data;
                tpc_pkg::REG_SS_TH:     cfg_reg.th[2] <= cfg_data;
                tpc_pkg::REG_DROP_TH:   cfg_reg.th[3] <= cfg_data;
                tpc_pkg::REG_RECOVERY:  cfg_reg.recovery  <= cfg_data[15:0];
                tpc_pkg::REG_CONS_SMP:  cfg_reg.cons_smp  <= cfg_data[15:0];
                tpc_pkg::REG_WATCH_SMP: cfg_reg.watch_smp <= cfg_data[15:0];
                tpc_pkg::REG_COOLDOWN:  cfg_reg.cooldown  <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    tpc_front #(.NUM_TARGETS(NUM_TARGETS)) u_front (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
        .q_data(q_data), .q_valid(q_valid), .q_ready(q_ready)
    );

    tpc_back #(.NUM_TARGETS(NUM_TARGETS), .MAX_RECS(MAX_RECS)) u_back (
        .clk(clk), .rst_n(rst_n), .cfg(cfg_reg),
        .q_data(q_data), .q_valid(q_valid), .q_ready(q_ready), .out_ch(out_ch)
    );
endmodule

// ----- bench/tpc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpc_checker
// Watches the command and status channels of the target pressure classifier,
// keeps its own copy of the target table, predicts each status beat and
// compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module tpc_checker
    import tpc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    tpc_in_if.sink      mon_in,
    tpc_out_if.sink     mon_out,
    input  logic        cfg_we,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output int          fail_count,
    output int          pending_count
);

    typedef struct packed {
        logic        entry_valid;
        logic [1:0]  level;
        logic [31:0] pressure_avg;
        logic [31:0] pending_avg;
        logic [15:0] watch_run;
        logic [15:0] constrained_run;
        logic [15:0] normal_run;
        logic [47:0] started_ms;
        logic [47:0] normal_since_out;
        logic        recommended;
        logic [2:0]  signal;
    } status_t;

    // register copy
    logic [63:0] thr [4];
    logic [15:0] recov_n, cons_n, watch_n;
    logic [31:0] cool_n;

    // target table copy
    logic        used [16];
    logic [1:0]  tmetric [16];
    level_t      tlevel [16];
    logic [31:0] p_avg [16];
    logic [31:0] b_avg [16];
    logic [15:0] w_run [16];
    logic [15:0] c_run [16];
    logic [15:0] n_run [16];
    logic [47:0] t_start [16];
    logic [47:0] t_norm [16];
    logic [47:0] t_last [16];
    int          rec_given;

    status_t status_q [$];

    assign pending_count = status_q.size();

    function automatic logic [31:0] blend(logic [31:0] o, logic [31:0] v);
        logic [33:0] w;
        w = 34'(o) * 3 + 34'(v);
        return w[33:2];
    endfunction

    function automatic logic [15:0] bump(logic [15:0] r);
        return (r == 16'hFFFF) ? r : r + 16'd1;
    endfunction

    task automatic apply_sample(int i, logic [1:0] m, logic [31:0] pv, logic [31:0] pb,
                                logic [47:0] now);
        logic [31:0] wt, ct;
        level_t prev;
        wt = thr[m][31:0];
        ct = thr[m][63:32];
        if (!used[i])
        begin
            used[i] = 1'b1;
            tlevel[i] = LVL_NORMAL;
            p_avg[i] = pv;
            b_avg[i] = pb;
            w_run[i] = '0; c_run[i] = '0; n_run[i] = '0;
            t_start[i] = '0; t_norm[i] = '0; t_last[i] = '0;
        end
        else
        begin
            p_avg[i] = blend(p_avg[i], pv);
            b_avg[i] = blend(b_avg[i], pb);
        end
        tmetric[i] = m;
        prev = tlevel[i];
        if (ct != 0 && p_avg[i] >= ct)
        begin
            tlevel[i] = LVL_CONSTRAINED;
            c_run[i] = bump(c_run[i]);
            w_run[i] = bump(w_run[i]);
            n_run[i] = '0;
            t_norm[i] = '0;
            if (t_start[i] == 0) t_start[i] = now;
        end
        else if (wt != 0 && p_avg[i] >= wt)
        begin
            tlevel[i] = LVL_WATCH;
            c_run[i] = '0;
            w_run[i] = bump(w_run[i]);
            n_run[i] = '0;
            t_norm[i] = '0;
            if (t_start[i] == 0) t_start[i] = now;
        end
        else
        begin
            tlevel[i] = LVL_NORMAL;
            c_run[i] = '0;
            w_run[i] = '0;
            n_run[i] = bump(n_run[i]);
            if (prev != LVL_NORMAL) t_norm[i] = now;
            if (n_run[i] >= recov_n) t_start[i] = '0;
        end
    endtask

    function automatic logic try_recommend(int i, logic [47:0] now);
        logic ok;
        if (!used[i] || rec_given >= MAX_RECS_DEF) return 1'b0;
        ok = (tlevel[i] == LVL_CONSTRAINED && c_run[i] >= cons_n) ||
             (tlevel[i] == LVL_WATCH && w_run[i] >= watch_n);
        if (!ok) return 1'b0;
        if (t_last[i] != 0)
        begin
            if (now < t_last[i]) return 1'b0;
            if (64'(now - t_last[i]) < 64'(cool_n)) return 1'b0;
        end
        t_last[i] = now;
        rec_given++;
        return 1'b1;
    endfunction

    // predict one status beat from an accepted command beat
    task automatic predict_status();
        status_t s;
        int i;
        logic rec;
        i = mon_in.target_index;
        rec = 1'b0;
        if (cmd_t'(mon_in.cmd) == CMD_ROUND) rec_given = 0;
        case (cmd_t'(mon_in.cmd))
            CMD_UPDATE: apply_sample(i, mon_in.metric, mon_in.pressure_sample,
                                     mon_in.pending_sample, mon_in.now_ms);
            CMD_CLEARED: if (used[i]) apply_sample(i, mon_in.metric, '0,
                                                   mon_in.pending_sample, mon_in.now_ms);
            CMD_RECOMMEND: rec = try_recommend(i, mon_in.now_ms);
            default: ;
        endcase
        s = '0;
        s.signal = NO_SIGNAL;
        if (used[i])
        begin
            s.entry_valid = 1'b1;
            s.level = tlevel[i];
            s.pressure_avg = p_avg[i];
            s.pending_avg = b_avg[i];
            s.watch_run = w_run[i];
            s.constrained_run = c_run[i];
            s.normal_run = n_run[i];
            s.started_ms = t_start[i];
            s.normal_since_out = t_norm[i];
            s.recommended = rec;
            s.signal = {1'b0, tmetric[i]};
        end
        status_q.insert(status_q.size(), s);
    endtask

    // compare one returned status beat
    task automatic check_status();
        status_t got, want;
        got = '{mon_out.entry_valid, mon_out.level, mon_out.pressure_avg,
                mon_out.pending_avg, mon_out.watch_run, mon_out.constrained_run,
                mon_out.normal_run, mon_out.started_ms, mon_out.normal_since_out,
                mon_out.recommended, mon_out.signal};
        if (status_q.size() == 0)
        begin
            fail_count++;
            if (fail_count <= 10) $display("unexpected status beat %h", got);
            return;
        end
        want = status_q.pop_front();
        if (got !== want)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("status mismatch at %0t: expected %h actual %h", $realtime, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr[0] <= '0; thr[1] <= '0; thr[2] <= '0; thr[3] <= '0;
            recov_n <= 16'd3; cons_n <= 16'd1; watch_n <= 16'd1; cool_n <= '0;
            for (int k = 0; k < 16; k++) used[k] <= 1'b0;
            rec_given <= 0;
            fail_count <= 0;
        end
        else
        begin
            if (mon_out.valid && mon_out.ready) check_status();
            if (mon_in.valid && mon_in.ready) predict_status();
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_PB_TH:     thr[0] = cfg_data;
                    REG_Q_TH:      thr[1] = cfg_data;
                    REG_SS_TH:     thr[2] = cfg_data;
                    REG_DROP_TH:   thr[3] = cfg_data;
                    REG_RECOVERY:  recov_n = cfg_data[15:0];
                    REG_CONS_SMP:  cons_n = cfg_data[15:0];
                    REG_WATCH_SMP: watch_n = cfg_data[15:0];
                    default:       cool_n = cfg_data[31:0];
                endcase
            end
        end
    end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives directed and random command beats into the target pressure
// classifier across several register settings, with random idling on both
// channels; the checker beside the block predicts and compares the results.
// ----------------------------------------------------------------------------
module tb_top;
    import tpc_pkg::*;

    localparam int LIMIT = 400000;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [REG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;
    int   fail_count;
    int   pending_count;
    int   cycles;
    logic calm;
    logic [47:0] clock_ms;

    tpc_in_if  in_ch ();
    tpc_out_if out_ch ();

    target_pressure_classifier u_dut (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    tpc_checker u_checker (
        .clk(clk), .rst_n(rst_n), .mon_in(in_ch.sink), .mon_out(out_ch.sink),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // timeout watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // result side stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) out_ch.ready <= 1'b0;
        else out_ch.ready <= calm || ($urandom_range(99) >= 9);
    end

    // one register write; write enable is dropped again before the task returns
    task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [63:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // stop sending and wait until every status beat is back
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    // send one command beat, with optional idle cycles in front
    task automatic send_beat(cmd_t c, logic [3:0] idx, logic [1:0] m, logic [31:0] pv,
                             logic [31:0] pb, logic [47:0] now);
        while (!calm && $urandom_range(99) < 9)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.cmd <= c;
        in_ch.target_index <= idx;
        in_ch.metric <= m;
        in_ch.pressure_sample <= pv;
        in_ch.pending_sample <= pb;
        in_ch.now_ms <= now;
        in_ch.rec_type <= 2'($urandom_range(2));
        do @(posedge clk); while (!in_ch.ready);
    endtask

    task automatic random_setting();
        for (int r = 0; r < 4; r++)
            write_reg(REG_IDX_W'(r), {32'($urandom_range(3000, 600)),
                                      32'($urandom_range(1500, 100))});
        write_reg(REG_RECOVERY, 64'($urandom_range(5)));
        write_reg(REG_CONS_SMP, 64'($urandom_range(4)));
        write_reg(REG_WATCH_SMP, 64'($urandom_range(4)));
        write_reg(REG_COOLDOWN, 64'($urandom_range(40)));
    endtask

    // random beats biased toward a few targets so runs build up
    task automatic random_phase(int n);
        cmd_t c;
        logic [31:0] pv;
        int pick;
        for (int k = 0; k < n; k++)
        begin
            pick = $urandom_range(99);
            c = (pick < 55) ? CMD_UPDATE : (pick < 65) ? CMD_CLEARED :
                (pick < 70) ? CMD_ROUND : CMD_RECOMMEND;
            pv = ($urandom_range(9) == 0) ? $urandom : 32'($urandom_range(4000));
            clock_ms = ($urandom_range(49) == 0) ? clock_ms - 48'($urandom_range(20))
                                                : clock_ms + 48'($urandom_range(15));
            send_beat(c, ($urandom_range(3) == 0) ? 4'($urandom) : 4'($urandom_range(3)),
                      2'($urandom), pv, $urandom, clock_ms);
        end
    endtask

    initial
    begin
        cycles = 0;
        calm = 1'b0;
        clock_ms = 48'd100;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.cmd = CMD_UPDATE;
        in_ch.target_index = '0;
        in_ch.metric = '0;
        in_ch.pressure_sample = '0;
        in_ch.pending_sample = '0;
        in_ch.now_ms = '0;
        in_ch.rec_type = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: missing entries, reset thresholds, extremes
        send_beat(CMD_RECOMMEND, 4'd5, 2'd0, '0, '0, 48'd1);
        send_beat(CMD_CLEARED, 4'd5, 2'd1, 32'd7, 32'd7, 48'd2);
        send_beat(CMD_ROUND, 4'd6, 2'd0, '0, '0, 48'd3);
        send_beat(CMD_UPDATE, 4'd15, 2'd3, '1, '1, '1);
        send_beat(CMD_UPDATE, 4'd15, 2'd3, '1, '1, '1);
        send_beat(CMD_RECOMMEND, 4'd15, 2'd3, '0, '0, 48'd4);
        drain();
        write_reg(REG_PB_TH, {32'd1000, 32'd100});
        write_reg(REG_Q_TH, {32'hFFFF_FFFF, 32'hFFFF_FFFF});
        write_reg(REG_SS_TH, {32'd0, 32'd50});
        write_reg(REG_DROP_TH, {32'd500, 32'd0});
        write_reg(REG_RECOVERY, 64'd0);
        write_reg(REG_CONS_SMP, 64'd2);
        write_reg(REG_WATCH_SMP, 64'd0);
        write_reg(REG_COOLDOWN, 64'hFFFF_FFFF);
        // watch then constrained, recommend at time 0, cooldown, recovery
        send_beat(CMD_UPDATE, 4'd0, 2'd0, 32'd200, 32'd10, 48'd10);
        send_beat(CMD_RECOMMEND, 4'd0, 2'd0, '0, '0, 48'd0);
        send_beat(CMD_RECOMMEND, 4'd0, 2'd0, '0, '0, 48'd11);
        send_beat(CMD_RECOMMEND, 4'd0, 2'd0, '0, '0, 48'd12);
        send_beat(CMD_UPDATE, 4'd0, 2'd0, 32'd5000, 32'd10, 48'd13);
        send_beat(CMD_UPDATE, 4'd0, 2'd0, 32'd5000, 32'd10, 48'd14);
        send_beat(CMD_RECOMMEND, 4'd0, 2'd0, '0, '0, 48'd5);
        send_beat(CMD_CLEARED, 4'd0, 2'd0, '0, 32'd0, 48'd15);
        send_beat(CMD_CLEARED, 4'd0, 2'd2, '0, 32'd0, 48'd16);
        send_beat(CMD_UPDATE, 4'd1, 2'd3, 32'd600, '1, 48'd17);
        send_beat(CMD_UPDATE, 4'd2, 2'd1, '1, 32'd1, 48'd18);
        // repeated recommends on target 2, then restart the round
        drain();
        write_reg(REG_COOLDOWN, 64'd0);
        for (int k = 0; k < 18; k++)
            send_beat(CMD_RECOMMEND, 4'd2, 2'd1, '0, '0, 48'(20 + k));
        send_beat(CMD_ROUND, 4'd2, 2'd0, '0, '0, 48'd40);
        send_beat(CMD_RECOMMEND, 4'd2, 2'd1, '0, '0, 48'd41);

        // random phases over several settings
        for (int ph = 0; ph < 6; ph++)
        begin
            drain();
            random_setting();
            if (ph == 2)
            begin
                write_reg(REG_RECOVERY, 64'hFFFF);
                write_reg(REG_CONS_SMP, 64'hFFFF);
                write_reg(REG_WATCH_SMP, 64'hFFFF);
            end
            calm = (ph == 3);
            random_phase(100);
            // hold off until every status beat is back
            drain();
            random_phase(100);
        end
        calm = 1'b0;
        drain();

        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- target_pressure_classifier.f -----
sv/tpc_pkg.sv
sv/tpc_in_if.sv
sv/tpc_out_if.sv
sv/tpc_front.sv
sv/tpc_back.sv
sv/target_pressure_classifier.sv
bench/tpc_checker.sv
bench/tb_top.sv
